// ----- design/tgq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgq_pkg: shared types, constants and helpers
// glyph table layout, fixed-point saturation and vertex corner selection
// ----------------------------------------------------------------------------
package tgq_pkg;

  // glyph table geometry
  localparam int GlyphCount = 96;
  localparam int IdxW       = (GlyphCount > 1) ? $clog2(GlyphCount) : 1;

  localparam logic [7:0] CodeFirst = 8'd32;
  localparam logic [7:0] CodeSpace = 8'd32;

  localparam logic OpChar  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [16:0]        TexOne    = 17'h10000;
  localparam logic signed [21:0] PosMax    = 22'sh1FFFFF;
  localparam logic signed [21:0] PosMin    = -22'sh200000;
  localparam logic [2:0]         LastVertex = 3'd5;

  typedef enum logic [2:0] {
    FieldULeft   = 3'd0,
    FieldVTop    = 3'd1,
    FieldURight  = 3'd2,
    FieldVBottom = 3'd3,
    FieldMinY    = 3'd4,
    FieldMaxY    = 3'd5,
    FieldMaxX    = 3'd6,
    FieldAdvance = 3'd7
  } field_e;

  typedef struct packed {
    logic [16:0]        u_left;
    logic [16:0]        v_top;
    logic [16:0]        u_right;
    logic [16:0]        v_bottom;
    logic signed [15:0] min_y;
    logic signed [15:0] max_y;
    logic signed [15:0] max_x;
    logic signed [15:0] advance;
  } glyph_t;

  typedef struct packed {
    logic [16:0]        u_l;
    logic [16:0]        u_r;
    logic [16:0]        v_t;
    logic [16:0]        v_b;
    logic signed [21:0] x_l;
    logic signed [21:0] x_r;
    logic signed [21:0] y_t;
    logic signed [21:0] y_b;
  } quad_t;

  // code has a table entry
  function automatic logic has_entry(logic [7:0] code);
    logic [8:0] diff;
    diff = {1'b0, code} - {1'b0, CodeFirst};
    return (code >= CodeFirst) && (diff < 9'(GlyphCount));
  endfunction

  function automatic logic [IdxW-1:0] entry_idx(logic [7:0] code);
    logic [7:0] diff;
    diff = code - CodeFirst;
    return diff[IdxW-1:0];
  endfunction

  function automatic logic [16:0] sat_tex(logic signed [17:0] v);
    if (v < 18'sd0) begin
      return 17'd0;
    end else if (v > 18'sd65536) begin
      return TexOne;
    end
    return v[16:0];
  endfunction

  function automatic logic signed [15:0] sat_metric(logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [21:0] sat_pos(logic signed [22:0] v);
    if (v[22] != v[21]) begin
      return v[22] ? PosMin : PosMax;
    end
    return v[21:0];
  endfunction

  // vertex order: LT LB RB LT RB RT
  function automatic logic vtx_right(logic [2:0] k);
    return (k == 3'd2) || (k == 3'd4) || (k == 3'd5);
  endfunction

  function automatic logic vtx_bottom(logic [2:0] k);
    return (k == 3'd1) || (k == 3'd2) || (k == 3'd4);
  endfunction

endpackage

// ----- design/tgq_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgq_in_if: input item channel
// character codes and glyph table writes, valid/ready handshake
// ----------------------------------------------------------------------------
interface tgq_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         char_code;
  logic [2:0]         field_select;
  logic signed [17:0] field_value;
  logic               first_char;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (
    output valid, op, char_code, field_select, field_value, first_char, start_x, start_y,
    input  ready
  );
  modport sink (
    input  valid, op, char_code, field_select, field_value, first_char, start_x, start_y,
    output ready
  );
endinterface

// ----- design/tgq_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgq_out_if: vertex result channel
// one textured vertex per beat, valid/ready handshake
// ----------------------------------------------------------------------------
interface tgq_out_if;
  logic               valid;
  logic               ready;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic signed [21:0] pos_x;
  logic signed [21:0] pos_y;
  logic               last_vertex;

  modport source (
    output valid, tex_u, tex_v, pos_x, pos_y, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, tex_u, tex_v, pos_x, pos_y, last_vertex,
    output ready
  );
endinterface

// ----- design/tgq_glyph_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgq_glyph_table: glyph metric memory
// one field written or one entry read per cycle, registered read data
// ----------------------------------------------------------------------------
module tgq_glyph_table (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic                     rd_en_i,
  input  logic [tgq_pkg::IdxW-1:0] addr_i,
  input  logic [2:0]               field_sel_i,
  input  logic signed [17:0]       value_i,
  output tgq_pkg::glyph_t          rd_data_o
);

  logic [16:0]        u_left_mem   [tgq_pkg::GlyphCount];
  logic [16:0]        v_top_mem    [tgq_pkg::GlyphCount];
  logic [16:0]        u_right_mem  [tgq_pkg::GlyphCount];
  logic [16:0]        v_bottom_mem [tgq_pkg::GlyphCount];
  logic signed [15:0] min_y_mem    [tgq_pkg::GlyphCount];
  logic signed [15:0] max_y_mem    [tgq_pkg::GlyphCount];
  logic signed [15:0] max_x_mem    [tgq_pkg::GlyphCount];
  logic signed [15:0] advance_mem  [tgq_pkg::GlyphCount];

  logic [16:0]        tex_val;
  logic signed [15:0] met_val;

  assign tex_val = tgq_pkg::sat_tex(value_i);
  assign met_val = tgq_pkg::sat_metric(value_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      case (tgq_pkg::field_e'(field_sel_i))
        tgq_pkg::FieldULeft:   u_left_mem[addr_i]   <= tex_val;
        tgq_pkg::FieldVTop:    v_top_mem[addr_i]    <= tex_val;
        tgq_pkg::FieldURight:  u_right_mem[addr_i]  <= tex_val;
        tgq_pkg::FieldVBottom: v_bottom_mem[addr_i] <= tex_val;
        tgq_pkg::FieldMinY:    min_y_mem[addr_i]    <= met_val;
        tgq_pkg::FieldMaxY:    max_y_mem[addr_i]    <= met_val;
        tgq_pkg::FieldMaxX:    max_x_mem[addr_i]    <= met_val;
        default:               advance_mem[addr_i]  <= met_val;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o.u_left   <= u_left_mem[addr_i];
      rd_data_o.v_top    <= v_top_mem[addr_i];
      rd_data_o.u_right  <= u_right_mem[addr_i];
      rd_data_o.v_bottom <= v_bottom_mem[addr_i];
      rd_data_o.min_y    <= min_y_mem[addr_i];
      rd_data_o.max_y    <= max_y_mem[addr_i];
      rd_data_o.max_x    <= max_x_mem[addr_i];
      rd_data_o.advance  <= advance_mem[addr_i];
    end
  end

endmodule

// ----- design/tgq_pen_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgq_pen_stage: pen position and quad corners
// holds the item whose glyph was read, computes its box and moves the pen
// ----------------------------------------------------------------------------
module tgq_pen_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               op_i,
  input  logic               hit_i,
  input  logic               space_i,
  input  logic               first_i,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  tgq_pkg::glyph_t    glyph_i,
  output logic               ready_o,
  output logic               quad_valid_o,
  input  logic               quad_ready_i,
  output tgq_pkg::quad_t     quad_o
);

  logic               valid_q;
  logic               op_q, hit_q, space_q, first_q;
  logic signed [15:0] sx_q, sy_q;
  logic signed [21:0] pen_x_q, pen_y_q;

  logic signed [21:0] pen_x_eff, pen_y_eff;
  logic               retire;

  assign pen_x_eff = first_q ? {sx_q, 6'b0} : pen_x_q;
  assign pen_y_eff = first_q ? {sy_q, 6'b0} : pen_y_q;

  assign quad_valid_o = valid_q && (op_q == tgq_pkg::OpChar) && hit_q && !space_q;
  assign retire       = valid_q && (!quad_valid_o || quad_ready_i);
  assign ready_o      = !valid_q || retire;

  always_comb begin
    quad_o.u_l = glyph_i.u_left;
    quad_o.u_r = glyph_i.u_right;
    quad_o.v_t = glyph_i.v_top;
    quad_o.v_b = glyph_i.v_bottom;
    quad_o.x_l = pen_x_eff;
    quad_o.x_r = tgq_pkg::sat_pos(23'(pen_x_eff) + 23'(glyph_i.max_x));
    quad_o.y_t = tgq_pkg::sat_pos(23'(pen_y_eff) - 23'(glyph_i.max_y));
    quad_o.y_b = tgq_pkg::sat_pos(23'(pen_y_eff) - 23'(glyph_i.min_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      if (accept_i) begin
        valid_q <= 1'b1;
      end else if (retire) begin
        valid_q <= 1'b0;
      end
      if (retire && (op_q == tgq_pkg::OpChar)) begin
        pen_x_q <= hit_q ? tgq_pkg::sat_pos(23'(pen_x_eff) + 23'(glyph_i.advance))
                         : pen_x_eff;
        pen_y_q <= pen_y_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q    <= op_i;
      hit_q   <= hit_i;
      space_q <= space_i;
      first_q <= first_i;
      sx_q    <= start_x_i;
      sy_q    <= start_y_i;
    end
  end

endmodule

// ----- design/tgq_vertex_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgq_vertex_seq: vertex sequencer
// steps a held quad through its six vertices into the output register
// ----------------------------------------------------------------------------
module tgq_vertex_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           quad_valid_i,
  output logic           quad_ready_o,
  input  tgq_pkg::quad_t quad_i,
  tgq_out_if.source      out_o
);

  logic           q_valid_q;
  tgq_pkg::quad_t q_q;
  logic [2:0]     cnt_q;
  logic           o_valid_q;
  logic           o_load, move, q_last;

  assign o_load       = !o_valid_q || out_o.ready;
  assign move         = q_valid_q && o_load;
  assign q_last       = cnt_q == tgq_pkg::LastVertex;
  assign quad_ready_o = !q_valid_q || (move && q_last);
  assign out_o.valid  = o_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
      cnt_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (quad_valid_i && quad_ready_o) begin
        q_valid_q <= 1'b1;
        cnt_q     <= '0;
      end else if (move) begin
        if (q_last) begin
          q_valid_q <= 1'b0;
        end
        cnt_q <= cnt_q + 3'd1;
      end
      if (o_load) begin
        o_valid_q <= move;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (quad_valid_i && quad_ready_o) begin
      q_q <= quad_i;
    end
    if (move) begin
      out_o.tex_u       <= tgq_pkg::vtx_right(cnt_q)  ? q_q.u_r : q_q.u_l;
      out_o.pos_x       <= tgq_pkg::vtx_right(cnt_q)  ? q_q.x_r : q_q.x_l;
      out_o.tex_v       <= tgq_pkg::vtx_bottom(cnt_q) ? q_q.v_b : q_q.v_t;
      out_o.pos_y       <= tgq_pkg::vtx_bottom(cnt_q) ? q_q.y_b : q_q.y_t;
      out_o.last_vertex <= q_last;
    end
  end

endmodule

// ----- design/text_glyph_quad_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_quad_generator_core: bitmap font text quad generator
// glyph metric table plus pen, six textured vertices per drawn character
// ----------------------------------------------------------------------------
//  port   | dir | beat
//  in_i   | in  | character code or one glyph table field write
//  out_o  | out | one vertex (u, v, x, y), last_vertex on the sixth
//
//  a drawn character gives six vertex beats at the output register; table
//  writes, spaces and codes without an entry give no vertex beat
//  the first vertex passes the pen stage, quad and output registers in turn
//  reset clears the pen and all valid flags; the glyph table is not cleared
//  a stalled output holds the sequencer, then the pen stage, then in_i.ready
// ----------------------------------------------------------------------------
module text_glyph_quad_generator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tgq_in_if.sink    in_i,
  tgq_out_if.source out_o
);

  logic            accept;
  logic            hit;
  tgq_pkg::glyph_t glyph;
  logic            quad_valid, quad_ready;
  tgq_pkg::quad_t  quad;

  // front end: the table is written or read in the cycle an item is taken
  assign accept = in_i.valid && in_i.ready;
  assign hit    = tgq_pkg::has_entry(in_i.char_code);

  tgq_glyph_table u_table (
    .clk_i       (clk_i),
    .wr_en_i     (accept && (in_i.op == tgq_pkg::OpWrite) && hit),
    .rd_en_i     (accept && (in_i.op == tgq_pkg::OpChar)),
    .addr_i      (tgq_pkg::entry_idx(in_i.char_code)),
    .field_sel_i (in_i.field_select),
    .value_i     (in_i.field_value),
    .rd_data_o   (glyph)
  );

  // pen stage: latches the pen on first character, builds the glyph box
  tgq_pen_stage u_pen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (in_i.op),
    .hit_i        (hit),
    .space_i      (in_i.char_code == tgq_pkg::CodeSpace),
    .first_i      (in_i.first_char),
    .start_x_i    (in_i.start_x),
    .start_y_i    (in_i.start_y),
    .glyph_i      (glyph),
    .ready_o      (in_i.ready),
    .quad_valid_o (quad_valid),
    .quad_ready_i (quad_ready),
    .quad_o       (quad)
  );

  // vertex sequencer and output register
  tgq_vertex_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quad_valid_i (quad_valid),
    .quad_ready_o (quad_ready),
    .quad_i       (quad),
    .out_o        (out_o)
  );

  // a blocked quad must hold the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quad_valid && !quad_ready) |-> !in_i.ready)
    else $error("input taken while quad blocked");

  // a table write never asks for a quad
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.op == tgq_pkg::OpWrite)) |=> !quad_valid)
    else $error("table write produced a quad");

  // a space never asks for a quad
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.char_code == tgq_pkg::CodeSpace)) |=> !quad_valid)
    else $error("space produced a quad");

  // loading a new quad never drops a vertex that waits at a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quad_valid && quad_ready && out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("output dropped while loading quad");

endmodule

// ----- sim/tb_text_glyph_quad_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_glyph_quad_generator_core: self-checking bench for the quad generator
// fills the glyph table, renders strings and compares every vertex beat with
// a behavioural copy of the table and pen, under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_text_glyph_quad_generator_core;
  import tgq_pkg::*;

  localparam int SubPixel      = 64;         // whole pixel to Q16.6
  localparam int MetricMax     = 32767;
  localparam int MetricMin     = -32768;
  localparam int WatchdogLimit = 1000;       // cycles with no beat on either side
  localparam int DrainCycles   = 20;         // tail after the last vertex
  localparam int RandomItems   = 250;

  localparam logic [7:0] CodeZero  = 8'd0;
  localparam logic [7:0] CodeLow   = 8'd5;
  localparam logic [7:0] CodeBelow = 8'd31;
  localparam logic [7:0] CodeA     = 8'd65;
  localparam logic [7:0] CodeAfter = CodeFirst + 8'd1;
  localparam logic [7:0] CodeLast  = 8'(int'(CodeFirst) + GlyphCount - 1);
  localparam logic [7:0] CodePast  = 8'(int'(CodeFirst) + GlyphCount);
  localparam logic [7:0] CodeTop   = 8'd255;
  localparam logic [7:0] AllFields = 8'hFF;

  // one input beat as the bench sees it
  typedef struct {
    logic               op;
    logic [7:0]         code;
    field_e             sel;
    logic signed [17:0] value;
    logic               first;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } text_beat_t;

  // one vertex beat
  typedef struct {
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [21:0] pos_x;
    logic signed [21:0] pos_y;
    logic               last_vertex;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tgq_in_if  in_if ();
  tgq_out_if out_if ();

  text_glyph_quad_generator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // beats still to be offered, and vertices still owed by the block
  text_beat_t text_stream_q[$];
  vertex_t    expected_vertices[$];

  // behavioural glyph table and pen
  logic [16:0]        font_u_left   [GlyphCount];
  logic [16:0]        font_v_top    [GlyphCount];
  logic [16:0]        font_u_right  [GlyphCount];
  logic [16:0]        font_v_bottom [GlyphCount];
  logic signed [15:0] font_min_y    [GlyphCount];
  logic signed [15:0] font_max_y    [GlyphCount];
  logic signed [15:0] font_max_x    [GlyphCount];
  logic signed [15:0] font_advance  [GlyphCount];
  logic signed [21:0] cursor_x = '0;
  logic signed [21:0] cursor_y = '0;

  // which fields of each entry the stimulus has written so far; a glyph is
  // only rendered once all eight are known, a space once its advance is
  logic [7:0] glyph_fields [GlyphCount];
  int         stim_count = 0;

  int         failures = 0;
  int         quiet_cycles = 0;
  int         send_gap = 0;
  int         send_calm = 0;
  int         recv_stall = 0;
  int         recv_calm = 0;
  int         recv_wait;
  text_beat_t cur_beat;
  text_beat_t next_beat;
  vertex_t    want_vertex;

  // --------------------------------------------------------------------------
  // arithmetic helpers
  // --------------------------------------------------------------------------
  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [21:0] pos_clip(longint v);
    return 22'(clip(v, PosMin, PosMax));
  endfunction

  function automatic logic in_table(logic [7:0] code);
    return (code >= CodeFirst) && (int'(code) - int'(CodeFirst) < GlyphCount);
  endfunction

  function automatic void push_vertex(logic [16:0] u, logic [16:0] v,
                                      logic signed [21:0] x, logic signed [21:0] y,
                                      logic last);
    vertex_t vx;
    vx.tex_u       = u;
    vx.tex_v       = v;
    vx.pos_x       = x;
    vx.pos_y       = y;
    vx.last_vertex = last;
    expected_vertices.push_back(vx);
  endfunction

  // --------------------------------------------------------------------------
  // predictor: updates table and pen for one accepted beat and queues the
  // vertices the block owes for it
  // --------------------------------------------------------------------------
  task automatic apply_beat(input text_beat_t b);
    int                 idx;
    logic signed [21:0] x_r, y_t, y_b;
    idx = int'(b.code) - int'(CodeFirst);
    if (b.op == OpWrite) begin
      // writes to codes outside the table vanish
      if (!in_table(b.code)) return;
      case (b.sel)
        FieldULeft:   font_u_left[idx]   = 17'(clip(b.value, 0, TexOne));
        FieldVTop:    font_v_top[idx]    = 17'(clip(b.value, 0, TexOne));
        FieldURight:  font_u_right[idx]  = 17'(clip(b.value, 0, TexOne));
        FieldVBottom: font_v_bottom[idx] = 17'(clip(b.value, 0, TexOne));
        FieldMinY:    font_min_y[idx]    = 16'(clip(b.value, MetricMin, MetricMax));
        FieldMaxY:    font_max_y[idx]    = 16'(clip(b.value, MetricMin, MetricMax));
        FieldMaxX:    font_max_x[idx]    = 16'(clip(b.value, MetricMin, MetricMax));
        default:      font_advance[idx]  = 16'(clip(b.value, MetricMin, MetricMax));
      endcase
      return;
    end
    // the pen is latched even when the code itself has no entry
    if (b.first) begin
      cursor_x = 22'(longint'(b.start_x) * SubPixel);
      cursor_y = 22'(longint'(b.start_y) * SubPixel);
    end
    if (!in_table(b.code)) return;
    if (b.code != CodeSpace) begin
      x_r = pos_clip(longint'(cursor_x) + longint'(font_max_x[idx]));
      y_t = pos_clip(longint'(cursor_y) - longint'(font_max_y[idx]));
      y_b = pos_clip(longint'(cursor_y) - longint'(font_min_y[idx]));
      // two counter-clockwise triangles: LT LB RB, LT RB RT
      push_vertex(font_u_left[idx],  font_v_top[idx],    cursor_x, y_t, 1'b0);
      push_vertex(font_u_left[idx],  font_v_bottom[idx], cursor_x, y_b, 1'b0);
      push_vertex(font_u_right[idx], font_v_bottom[idx], x_r,      y_b, 1'b0);
      push_vertex(font_u_left[idx],  font_v_top[idx],    cursor_x, y_t, 1'b0);
      push_vertex(font_u_right[idx], font_v_bottom[idx], x_r,      y_b, 1'b0);
      push_vertex(font_u_right[idx], font_v_top[idx],    x_r,      y_t, 1'b1);
    end
    cursor_x = pos_clip(longint'(cursor_x) + longint'(font_advance[idx]));
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly in range, now and then anything the 18-bit field can carry
  function automatic logic signed [17:0] random_field_value(field_e sel);
    if (sel < FieldMinY) begin
      if ($urandom_range(0, 5) == 0) return 18'($urandom);
      return 18'($urandom_range(0, 65536));
    end
    case ($urandom_range(0, 7))
      0:       return 18'($urandom);
      1:       return 18'(shortint'($urandom));
      default: return 18'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic logic signed [15:0] start_coord();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2000)) - 1000);
  endfunction

  // table codes, with codes near both ends of the table drawn often
  function automatic logic [7:0] table_code();
    case ($urandom_range(0, 5))
      0:       return CodeLast;
      1:       return CodeAfter;
      default: return 8'($urandom_range(int'(CodeFirst), int'(CodeLast)));
    endcase
  endfunction

  function automatic logic [7:0] no_entry_code();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, int'(CodeFirst) - 1));
    return 8'($urandom_range(int'(CodePast), int'(CodeTop)));
  endfunction

  function automatic logic [7:0] drawable_code();
    int pool[$];
    foreach (glyph_fields[i]) begin
      if (glyph_fields[i] == AllFields) pool.push_back(i);
    end
    return 8'(pool[$urandom_range(0, pool.size() - 1)] + int'(CodeFirst));
  endfunction

  task automatic queue_write(input logic [7:0] code, input field_e sel,
                             input logic signed [17:0] value);
    text_beat_t b;
    b.op      = OpWrite;
    b.code    = code;
    b.sel     = sel;
    b.value   = value;
    b.first   = 1'($urandom_range(0, 1));
    b.start_x = 16'($urandom);
    b.start_y = 16'($urandom);
    text_stream_q.push_back(b);
    if (in_table(code)) begin
      glyph_fields[int'(code) - int'(CodeFirst)][sel] = 1'b1;
      stim_count++;
    end
  endtask

  task automatic queue_char(input logic [7:0] code, input logic first,
                            input logic signed [15:0] sx, input logic signed [15:0] sy);
    text_beat_t b;
    b.op      = OpChar;
    b.code    = code;
    b.sel     = field_e'($urandom_range(0, 7));
    b.value   = 18'($urandom);
    b.first   = first;
    b.start_x = sx;
    b.start_y = sy;
    text_stream_q.push_back(b);
    if (in_table(code) || first) stim_count++;
  endtask

  task automatic queue_glyph(input logic [7:0] code);
    for (int f = 0; f < 8; f++) begin
      queue_write(code, field_e'(f), random_field_value(field_e'(f)));
    end
  endtask

  // a random gap, broken by stretches with no gaps at all
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // --------------------------------------------------------------------------
  // driver: holds each beat until taken, then waits its drawn gap
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.op           <= OpChar;
      in_if.char_code    <= '0;
      in_if.field_select <= '0;
      in_if.field_value  <= '0;
      in_if.first_char   <= 1'b0;
      in_if.start_x      <= '0;
      in_if.start_y      <= '0;
      send_gap           <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_beat(cur_beat);
      end
      // the slot is free when nothing is offered or the offer was just taken
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (text_stream_q.size() > 0) begin
          next_beat          = text_stream_q.pop_front();
          cur_beat           = next_beat;
          in_if.op           <= next_beat.op;
          in_if.char_code    <= next_beat.code;
          in_if.field_select <= next_beat.sel;
          in_if.field_value  <= next_beat.value;
          in_if.first_char   <= next_beat.first;
          in_if.start_x      <= next_beat.start_x;
          in_if.start_y      <= next_beat.start_y;
          in_if.valid        <= 1'b1;
          send_gap           <= draw_wait(send_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each vertex beat, then drops ready for a drawn stall
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_vertices.size() == 0) begin
          $error("vertex beat with no vertex owed: u %0d v %0d x %0d y %0d",
                 out_if.tex_u, out_if.tex_v, out_if.pos_x, out_if.pos_y);
          failures++;
        end else begin
          want_vertex = expected_vertices.pop_front();
          if (out_if.tex_u !== want_vertex.tex_u) begin
            $error("tex_u: expected %0d, got %0d", want_vertex.tex_u, out_if.tex_u);
            failures++;
          end
          if (out_if.tex_v !== want_vertex.tex_v) begin
            $error("tex_v: expected %0d, got %0d", want_vertex.tex_v, out_if.tex_v);
            failures++;
          end
          if (out_if.pos_x !== want_vertex.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want_vertex.pos_x, out_if.pos_x);
            failures++;
          end
          if (out_if.pos_y !== want_vertex.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want_vertex.pos_y, out_if.pos_y);
            failures++;
          end
          if (out_if.last_vertex !== want_vertex.last_vertex) begin
            $error("last_vertex: expected %0d, got %0d",
                   want_vertex.last_vertex, out_if.last_vertex);
            failures++;
          end
        end
        recv_wait    = draw_wait(recv_calm);
        recv_stall   <= recv_wait;
        out_if.ready <= (recv_wait == 0);
      end else if (recv_stall > 0) begin
        recv_stall   <= recv_stall - 1;
        out_if.ready <= (recv_stall == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: a hung handshake on either side ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WatchdogLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchdogLimit);
        $display("FAIL text_glyph_quad_generator_core");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int         len;
    int         pick;
    logic [7:0] code;
    field_e     sel;

    rst_ni = 1'b0;
    foreach (glyph_fields[i]) glyph_fields[i] = '0;

    // directed: one glyph with saturating texture and metric values
    queue_write(CodeA, FieldULeft,   18'sh20000);
    queue_write(CodeA, FieldVTop,    18'sh1FFFF);
    queue_write(CodeA, FieldURight,  18'sd65536);
    queue_write(CodeA, FieldVBottom, 18'sd40000);
    queue_write(CodeA, FieldMinY,    -18'sd40000);
    queue_write(CodeA, FieldMaxY,    18'sd40000);
    queue_write(CodeA, FieldMaxX,    18'sd32767);
    queue_write(CodeA, FieldAdvance, -18'sd32768);
    // writes just outside the table are dropped; the space gets its advance
    queue_write(CodeBelow, FieldAdvance, 18'sd100);
    queue_write(CodePast, FieldULeft, 18'sd5);
    queue_write(CodeSpace, FieldAdvance, 18'sd32767);
    // pen at the far right and top: right edge and top edge saturate
    queue_char(CodeA, 1'b1, 16'sh7FFF, 16'sh8000);
    // spaces draw nothing but advance, the second one into saturation
    queue_char(CodeSpace, 1'b0, 16'sd0, 16'sd0);
    queue_char(CodeSpace, 1'b0, 16'sd0, 16'sd0);
    queue_char(CodeA, 1'b0, 16'sd0, 16'sd0);
    // a first character without an entry still latches the pen
    queue_char(CodeLow, 1'b1, 16'sh8000, 16'sh7FFF);
    // bottom edge saturates high, advance pushes the pen to its minimum
    queue_char(CodeA, 1'b0, 16'sd0, 16'sd0);
    // codes without entry neither draw nor advance the pen; one flagged first latches it
    queue_char(CodePast, 1'b0, 16'sd0, 16'sd0);
    queue_char(CodeTop, 1'b0, 16'sd0, 16'sd0);
    queue_char(CodeZero, 1'b0, 16'sd0, 16'sd0);
    queue_char(CodeA, 1'b0, 16'sd0, 16'sd0);
    queue_char(CodeBelow, 1'b1, 16'sd0, 16'sd0);
    queue_char(CodeA, 1'b0, 16'sd0, 16'sd0);

    // random: complete glyphs near both ends of the table first
    queue_glyph(CodeAfter);
    queue_glyph(CodeLast);
    queue_glyph(table_code());
    while (stim_count < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1: queue_glyph(table_code());
        2: begin
          len = $urandom_range(1, 4);
          for (int n = 0; n < len; n++) begin
            sel = field_e'($urandom_range(0, 7));
            queue_write(table_code(), sel, random_field_value(sel));
          end
        end
        9: begin
          // noise: dropped writes and codes without an entry
          if ($urandom_range(0, 1) == 0) begin
            queue_write(no_entry_code(), field_e'($urandom_range(0, 7)), 18'($urandom));
          end else begin
            queue_char(no_entry_code(), 1'($urandom_range(0, 1)), start_coord(),
                       start_coord());
          end
        end
        default: begin
          // a string: pen latched on its first character, rarely again later
          len = $urandom_range(1, 8);
          for (int n = 0; n < len; n++) begin
            pick = $urandom_range(0, 11);
            if (pick == 0 && glyph_fields[0][FieldAdvance]) begin
              code = CodeSpace;
            end else if (pick == 1) begin
              code = no_entry_code();
            end else begin
              code = drawable_code();
            end
            queue_char(code, (n == 0) || ($urandom_range(0, 9) == 0), start_coord(),
                       start_coord());
          end
        end
      endcase
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all beats offered and taken, then every owed vertex seen
    while (text_stream_q.size() != 0 || in_if.valid) @(negedge clk_i);
    while (expected_vertices.size() != 0) @(negedge clk_i);
    // let any stray vertex show up
    repeat (DrainCycles) @(negedge clk_i);

    if (failures == 0) begin
      $display("PASS text_glyph_quad_generator_core");
    end else begin
      $display("FAIL text_glyph_quad_generator_core");
    end
    $finish;
  end

endmodule
